/* rtl/i2cram_pkg.sv */
// ----------------------------------------------------------------------------
// i2cram_pkg
// Types and constants shared by the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] RegHalfBitTicks = 2'd0;
  localparam logic [1:0] RegAckPollLimit = 2'd1;
  localparam logic [1:0] RegSlaveAddress = 2'd2;

  localparam logic [7:0] HalfBitTicksRst = 8'd2;
  localparam logic [7:0] AckPollLimitRst = 8'd250;
  localparam logic [6:0] SlaveAddressRst = 7'd13;

  localparam logic [7:0] PtrCmd = 8'hB0;

  typedef enum logic [12:0] {
    PhIdle     = 13'b0000000000001,
    PhStartA   = 13'b0000000000010,
    PhStartB   = 13'b0000000000100,
    PhTxLow    = 13'b0000000001000,
    PhTxHigh   = 13'b0000000010000,
    PhAckLow   = 13'b0000000100000,
    PhAckHigh  = 13'b0000001000000,
    PhRxLow    = 13'b0000010000000,
    PhRxHigh   = 13'b0000100000000,
    PhNackLow  = 13'b0001000000000,
    PhNackHigh = 13'b0010000000000,
    PhStopA    = 13'b0100000000000,
    PhStopB    = 13'b1000000000000
  } phase_e;

  typedef struct packed {
    logic [7:0] half_bit_ticks;
    logic [7:0] ack_poll_limit;
    logic [6:0] slave_address;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic       is_read;
    logic [7:0] reg_address;
    logic [7:0] write_value;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
  } result_t;

endpackage

/* rtl/i2cram_cfg.sv */
// ----------------------------------------------------------------------------
// i2cram_cfg
// APB-style configuration registers: half bit ticks, ACK poll limit, address.
// ----------------------------------------------------------------------------
module i2cram_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cram_pkg::AddrW-1:0]  paddr,
  input  logic [i2cram_pkg::DataW-1:0]  pwdata,
  output logic [i2cram_pkg::DataW-1:0]  prdata,
  output logic                          pready,
  output i2cram_pkg::cfg_t              cfg_o
);

  i2cram_pkg::cfg_t cfg_q, cfg_d;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        i2cram_pkg::RegHalfBitTicks: cfg_d.half_bit_ticks = pwdata[7:0];
        i2cram_pkg::RegAckPollLimit: cfg_d.ack_poll_limit = pwdata[7:0];
        i2cram_pkg::RegSlaveAddress: cfg_d.slave_address  = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      i2cram_pkg::RegHalfBitTicks: prdata = {24'd0, cfg_q.half_bit_ticks};
      i2cram_pkg::RegAckPollLimit: prdata = {24'd0, cfg_q.ack_poll_limit};
      i2cram_pkg::RegSlaveAddress: prdata = {25'd0, cfg_q.slave_address};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks <= i2cram_pkg::HalfBitTicksRst;
      cfg_q.ack_poll_limit <= i2cram_pkg::AckPollLimitRst;
      cfg_q.slave_address  <= i2cram_pkg::SlaveAddressRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/i2cram_engine.sv */
// ----------------------------------------------------------------------------
// i2cram_engine
// Bus phase sequencer: advances the access by one request per cycle while
// step_i is high and forms the line levels and status that follow the update.
// ----------------------------------------------------------------------------
module i2cram_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2cram_pkg::item_t    item_i,
  input  i2cram_pkg::cfg_t     cfg_i,
  output i2cram_pkg::result_t  res_o
);

  i2cram_pkg::phase_e phase_q, phase_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] ack_q, ack_d;
  logic [3:0] bit_idx_q, bit_idx_d;
  logic [1:0] step_q, step_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] val_q, val_d;
  logic       rd_q, rd_d;
  logic [7:0] recv_q, recv_d;
  logic       err_q, err_d;
  logic       done;

  logic [7:0] half_ticks;
  logic [7:0] tick_inc;
  logic       elapsed;
  logic [7:0] rx_shift;
  logic [1:0] step_next;

  function automatic logic [7:0] byte_for(input logic [1:0] stp, input logic rd,
                                          input logic [7:0] adr, input logic [7:0] val,
                                          input logic [6:0] slv);
    logic [7:0] wr;
    wr = {slv, 1'b0};
    unique case (stp)
      2'd0:    byte_for = wr;
      2'd1:    byte_for = rd ? i2cram_pkg::PtrCmd : adr;
      2'd2:    byte_for = rd ? adr : val;
      default: byte_for = {slv, 1'b1};
    endcase
  endfunction

  assign half_ticks = (cfg_i.half_bit_ticks == 8'd0) ? 8'd1 : cfg_i.half_bit_ticks;
  assign tick_inc   = (tick_q == 8'hFF) ? 8'hFF : tick_q + 8'd1;
  assign elapsed    = tick_inc >= half_ticks;
  assign rx_shift   = {shift_q[6:0], item_i.sda_sample};
  assign step_next  = step_q + 2'd1;

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    ack_d     = ack_q;
    bit_idx_d = bit_idx_q;
    step_d    = step_q;
    shift_d   = shift_q;
    addr_d    = addr_q;
    val_d     = val_q;
    rd_d      = rd_q;
    recv_d    = recv_q;
    err_d     = err_q;
    done      = 1'b0;

    if (item_i.kind) begin
      // ignore a command while an access runs
      if (phase_q == i2cram_pkg::PhIdle) begin
        rd_d      = item_i.is_read;
        addr_d    = item_i.reg_address;
        val_d     = item_i.write_value;
        err_d     = 1'b0;
        step_d    = 2'd0;
        bit_idx_d = 4'd0;
        ack_d     = 8'd0;
        tick_d    = 8'd0;
        phase_d   = i2cram_pkg::PhStartA;
      end
    end else if (phase_q != i2cram_pkg::PhIdle) begin
      unique case (phase_q)
        i2cram_pkg::PhStartA: begin
          tick_d = tick_inc;
          if (elapsed) begin
            tick_d  = 8'd0;
            phase_d = i2cram_pkg::PhStartB;
          end
        end
        i2cram_pkg::PhStartB: begin
          tick_d = tick_inc;
          if (elapsed) begin
            shift_d   = byte_for(step_q, rd_q, addr_q, val_q, cfg_i.slave_address);
            bit_idx_d = 4'd0;
            tick_d    = 8'd0;
            phase_d   = i2cram_pkg::PhTxLow;
          end
        end
        i2cram_pkg::PhTxLow: begin
          tick_d = tick_inc;
          if (elapsed) begin
            tick_d  = 8'd0;
            phase_d = i2cram_pkg::PhTxHigh;
          end
        end
        i2cram_pkg::PhTxHigh: begin
          tick_d = tick_inc;
          if (elapsed) begin
            shift_d   = {shift_q[6:0], 1'b0};
            bit_idx_d = bit_idx_q + 4'd1;
            tick_d    = 8'd0;
            if (bit_idx_q >= 4'd7) begin
              ack_d   = 8'd0;
              phase_d = i2cram_pkg::PhAckLow;
            end else begin
              phase_d = i2cram_pkg::PhTxLow;
            end
          end
        end
        i2cram_pkg::PhAckLow: begin
          tick_d = tick_inc;
          if (elapsed) begin
            tick_d  = 8'd0;
            phase_d = i2cram_pkg::PhAckHigh;
          end
        end
        i2cram_pkg::PhAckHigh: begin
          if (!item_i.sda_sample) begin
            tick_d = 8'd0;
            if (step_q == 2'd3) begin
              shift_d   = 8'd0;
              bit_idx_d = 4'd0;
              phase_d   = i2cram_pkg::PhRxLow;
            end else if (step_q == 2'd2) begin
              phase_d = i2cram_pkg::PhStopA;
            end else begin
              step_d    = step_next;
              shift_d   = byte_for(step_next, rd_q, addr_q, val_q, cfg_i.slave_address);
              bit_idx_d = 4'd0;
              phase_d   = i2cram_pkg::PhTxLow;
            end
          end else if (ack_q >= cfg_i.ack_poll_limit) begin
            // no ACK in time: abort with a STOP
            err_d   = 1'b1;
            tick_d  = 8'd0;
            phase_d = i2cram_pkg::PhStopA;
          end else begin
            ack_d = ack_q + 8'd1;
          end
        end
        i2cram_pkg::PhRxLow: begin
          tick_d = tick_inc;
          if (elapsed) begin
            tick_d  = 8'd0;
            phase_d = i2cram_pkg::PhRxHigh;
          end
        end
        i2cram_pkg::PhRxHigh: begin
          tick_d = tick_inc;
          if (elapsed) begin
            shift_d   = rx_shift;
            bit_idx_d = bit_idx_q + 4'd1;
            tick_d    = 8'd0;
            if (bit_idx_q >= 4'd7) begin
              recv_d  = rx_shift;
              phase_d = i2cram_pkg::PhNackLow;
            end else begin
              phase_d = i2cram_pkg::PhRxLow;
            end
          end
        end
        i2cram_pkg::PhNackLow: begin
          tick_d = tick_inc;
          if (elapsed) begin
            tick_d  = 8'd0;
            phase_d = i2cram_pkg::PhNackHigh;
          end
        end
        i2cram_pkg::PhNackHigh: begin
          tick_d = tick_inc;
          if (elapsed) begin
            tick_d  = 8'd0;
            phase_d = i2cram_pkg::PhStopA;
          end
        end
        i2cram_pkg::PhStopA: begin
          tick_d = tick_inc;
          if (elapsed) begin
            tick_d  = 8'd0;
            phase_d = i2cram_pkg::PhStopB;
          end
        end
        i2cram_pkg::PhStopB: begin
          tick_d = tick_inc;
          if (elapsed) begin
            tick_d = 8'd0;
            // after a clean pointer set, go on to the read part
            if (rd_q && (step_q == 2'd2) && !err_q) begin
              step_d  = 2'd3;
              phase_d = i2cram_pkg::PhStartA;
            end else begin
              phase_d = i2cram_pkg::PhIdle;
              done    = 1'b1;
            end
          end
        end
        default: phase_d = i2cram_pkg::PhIdle;
      endcase
    end
  end

  // line levels and status after the update
  always_comb begin
    res_o.done_res  = done;
    res_o.busy_res  = (phase_d != i2cram_pkg::PhIdle);
    res_o.read_byte = recv_d;
    res_o.ack_error = err_d;
    unique case (phase_d)
      i2cram_pkg::PhStartB: begin
        res_o.scl_level    = 1'b1;
        res_o.sda_pull_low = 1'b1;
      end
      i2cram_pkg::PhTxLow: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = !shift_d[7];
      end
      i2cram_pkg::PhTxHigh: begin
        res_o.scl_level    = 1'b1;
        res_o.sda_pull_low = !shift_d[7];
      end
      i2cram_pkg::PhAckLow, i2cram_pkg::PhRxLow, i2cram_pkg::PhNackLow: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = 1'b0;
      end
      i2cram_pkg::PhStopA: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = 1'b1;
      end
      i2cram_pkg::PhStopB: begin
        res_o.scl_level    = 1'b1;
        res_o.sda_pull_low = 1'b1;
      end
      default: begin
        res_o.scl_level    = 1'b1;
        res_o.sda_pull_low = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= i2cram_pkg::PhIdle;
      tick_q    <= 8'd0;
      ack_q     <= 8'd0;
      bit_idx_q <= 4'd0;
      step_q    <= 2'd0;
      shift_q   <= 8'd0;
      addr_q    <= 8'd0;
      val_q     <= 8'd0;
      rd_q      <= 1'b0;
      recv_q    <= 8'd0;
      err_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      ack_q     <= ack_d;
      bit_idx_q <= bit_idx_d;
      step_q    <= step_d;
      shift_q   <= shift_d;
      addr_q    <= addr_d;
      val_q     <= val_d;
      rd_q      <= rd_d;
      recv_q    <= recv_d;
      err_q     <= err_d;
    end
  end

endmodule

/* rtl/i2c_register_access_master.sv */
// ----------------------------------------------------------------------------
// i2c_register_access_master
// I2C master for single register writes and pointer-set-then-read accesses.
// ----------------------------------------------------------------------------
// Each request is either one tick of bus time or an access command, and the
// block takes one request per clock cycle while the output is not stalled:
// it is held in an input register, and when it is stepped the phase
// sequencer updates its state as the levels and status land in a result
// register. The sequencer update is what sets the one-request-per-cycle
// throughput. While a result waits to be taken, one more request is
// accepted into the input register. SCL and SDA timing is counted in
// ticks as set by half_bit_ticks; a command sent while an access runs is
// dropped and yields only a status result.
module i2c_register_access_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cram_pkg::AddrW-1:0]  paddr,
  input  logic [i2cram_pkg::DataW-1:0]  pwdata,
  output logic [i2cram_pkg::DataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic                          is_read_i,
  input  logic [7:0]                    reg_address_i,
  input  logic [7:0]                    write_value_i,
  input  logic                          sda_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          scl_level_o,
  output logic                          sda_pull_low_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic [7:0]                    read_byte_o,
  output logic                          ack_error_o
);

  i2cram_pkg::cfg_t    cfg;
  i2cram_pkg::item_t   item_q, item_d;
  i2cram_pkg::result_t res, res_q;
  logic                in_valid_q, in_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                out_ready;
  logic                step;
  logic                in_take;

  i2cram_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.kind        = kind_i;
    item_d.is_read     = is_read_i;
    item_d.reg_address = reg_address_i;
    item_d.write_value = write_value_i;
    item_d.sda_sample  = sda_sample_i;
  end

  always_comb begin
    priority if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  assign out_valid_d = out_ready ? step : out_valid_q;

  i2cram_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: item loads on take, result on step, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_level_o    = res_q.scl_level;
  assign sda_pull_low_o = res_q.sda_pull_low;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign read_byte_o    = res_q.read_byte;
  assign ack_error_o    = res_q.ack_error;

endmodule
